// File: hw/rtl/uwcl_pkg.sv
package uwcl_pkg;

	localparam int unsigned ByteW      = 8;
	localparam int unsigned MaxResults = 4;
	localparam int unsigned FifoDepth  = 8;
	localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
	localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);
	localparam int unsigned SlotCntW   = $clog2(MaxResults + 1);
	localparam int unsigned SlotIdxW   = $clog2(MaxResults);

	localparam logic [ByteW-1:0] ChNul   = 8'h00;
	localparam logic [ByteW-1:0] ChTab   = 8'h09;
	localparam logic [ByteW-1:0] ChCr    = 8'h0D;
	localparam logic [ByteW-1:0] ChSpace = 8'h20;
	localparam logic [ByteW-1:0] ChUpA   = 8'h41;
	localparam logic [ByteW-1:0] ChUpZ   = 8'h5A;
	localparam logic [ByteW-1:0] ChCont  = 8'h80;
	localparam logic [ByteW-1:0] ChFoldHi = 8'h9E;
	localparam logic [ByteW-1:0] ChTimes = 8'h97;
	localparam logic [ByteW-1:0] ChNbsp2 = 8'hA0;
	localparam logic [ByteW-1:0] ChLsep3 = 8'hA8;
	localparam logic [ByteW-1:0] ChPsep3 = 8'hA9;
	localparam logic [ByteW-1:0] ChC2    = 8'hC2;
	localparam logic [ByteW-1:0] ChC3    = 8'hC3;
	localparam logic [ByteW-1:0] ChE2    = 8'hE2;
	localparam logic [ByteW-1:0] ChE3    = 8'hE3;
	localparam logic [ByteW-1:0] CaseOfs = 8'h20;

	typedef enum logic [1:0] {
		HELD_NONE = 2'd0,
		HELD_C2   = 2'd1,
		HELD_E2   = 2'd2,
		HELD_E3   = 2'd3
	} held_kind_t;

	typedef struct packed {
		logic             last;
		logic [ByteW-1:0] data;
	} out_word_t;

	function automatic logic [ByteW-1:0] held_lead_byte(input held_kind_t k);
		logic [ByteW-1:0] r;
		case (k)
			HELD_C2: r = ChC2;
			HELD_E2: r = ChE2;
			HELD_E3: r = ChE3;
			default: r = ChNul;
		endcase
		return r;
	endfunction

	// returns {c3 flag after this byte, lowercased byte}
	function automatic logic [ByteW:0] fold_byte(input logic [ByteW-1:0] b, input logic c3);
		logic [ByteW-1:0] v;
		logic             c3_n;
		v = b;
		if (c3 && b >= ChCont && b <= ChFoldHi && b != ChTimes) begin
			v    = b + CaseOfs;
			c3_n = 1'b0;
		end else begin
			if (b >= ChUpA && b <= ChUpZ) v = b + CaseOfs;
			c3_n = (v == ChC3);
		end
		return {c3_n, v};
	endfunction

endpackage

// File: hw/rtl/utf8_whitespace_collapse_lower.sv
// channel | dir | handshake         | payload
// s       | in  | s_tvalid/s_tready | s_tdata[7:0] = in_byte
// m       | out | m_tvalid/m_tready | m_tdata[7:0] = out_byte, m_tlast = is_last
//
// one input byte per cycle: input register, then one pass of logic that pushes
// 0..4 words into an 8-word output queue; the queue drains one word per cycle while m_tready is high
// the input register advances only while the queue has room for four words,
// so bursts of several words per byte stall the input side
// arst_n clears the scan state and the input register's valid flag, and empties the queue
module utf8_whitespace_collapse_lower (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [uwcl_pkg::ByteW-1:0] s_tdata,   // [7:0] in_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [uwcl_pkg::ByteW-1:0] m_tdata,   // [7:0] out_byte
	output logic                       m_tlast    // is_last
);
	import uwcl_pkg::*;

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;

	held_kind_t held_kind_q, held_kind_d;
	logic       held_second_q, held_second_d;
	logic       space_pend_q, space_pend_d;
	logic       emitted_q, emitted_d;
	logic       prev_c3_q, prev_c3_d;

	out_word_t             fifo_mem [FifoDepth];
	logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FifoCntW-1:0]   fifo_cnt_q;

	out_word_t             slot [MaxResults];
	logic [SlotCntW-1:0]   n_push;
	logic                  advance;
	logic                  pop;
	logic [SlotCntW-1:0]   push_cnt;

	assign advance  = valid_s1 && (fifo_cnt_q <= FifoCntW'(FifoDepth - MaxResults));
	assign s_tready = !valid_s1 || advance;
	assign pop      = m_tvalid && m_tready;
	assign push_cnt = advance ? n_push : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) byte_s1 <= s_tdata;
	end

	// one byte of the scan: raw words in order, then the case fold chain
	always_comb begin
		logic [ByteW-1:0] raw [MaxResults];
		logic [MaxResults-1:0] lst;
		logic [SlotCntW-1:0] n;
		logic sp;
		logic em;
		logic flush;
		logic captured;
		logic c3;
		logic [ByteW:0] f;
		logic [ByteW-1:0] b;

		b             = byte_s1;
		n             = '0;
		lst           = '0;
		sp            = space_pend_q;
		em            = emitted_q;
		flush         = 1'b0;
		captured      = 1'b0;
		held_kind_d   = held_kind_q;
		held_second_d = held_second_q;
		for (int i = 0; i < MaxResults; i++) raw[i] = ChNul;

		case (held_kind_q)
			HELD_C2: begin
				if (b == ChNbsp2) captured = 1'b1;
				else flush = 1'b1;
			end
			HELD_E2, HELD_E3: begin
				if (!held_second_q) begin
					if (b == ChCont) begin
						captured      = 1'b1;
						held_second_d = 1'b1;
					end else begin
						flush = 1'b1;
					end
				end else if (held_kind_q == HELD_E2) begin
					if (b == ChLsep3 || b == ChPsep3) captured = 1'b1;
					else flush = 1'b1;
				end else begin
					if (b == ChCont) captured = 1'b1;
					else flush = 1'b1;
				end
			end
			default: ;
		endcase

		if (captured) begin
			// multi-byte space complete unless only the second byte arrived
			if (!held_second_d || held_second_q) begin
				held_kind_d   = HELD_NONE;
				held_second_d = 1'b0;
				if (em) sp = 1'b1;
			end
		end else begin
			if (flush) begin
				if (sp) begin
					raw[n[SlotIdxW-1:0]] = ChSpace;
					n      = n + 1'b1;
					sp     = 1'b0;
				end
				raw[n[SlotIdxW-1:0]] = held_lead_byte(held_kind_q);
				n      = n + 1'b1;
				if (held_second_q) begin
					raw[n[SlotIdxW-1:0]] = ChCont;
					n      = n + 1'b1;
				end
				em            = 1'b1;
				held_kind_d   = HELD_NONE;
				held_second_d = 1'b0;
			end
			if (b == ChNul) begin
				raw[n[SlotIdxW-1:0]] = ChNul;
				lst[n[SlotIdxW-1:0]] = 1'b1;
				n      = n + 1'b1;
			end else if (b == ChSpace || (b >= ChTab && b <= ChCr)) begin
				if (em) sp = 1'b1;
			end else if (b == ChC2) begin
				held_kind_d = HELD_C2;
			end else if (b == ChE2) begin
				held_kind_d = HELD_E2;
			end else if (b == ChE3) begin
				held_kind_d = HELD_E3;
			end else begin
				if (sp) begin
					raw[n[SlotIdxW-1:0]] = ChSpace;
					n      = n + 1'b1;
					sp     = 1'b0;
				end
				raw[n[SlotIdxW-1:0]] = b;
				n      = n + 1'b1;
				em     = 1'b1;
			end
		end

		c3 = prev_c3_q;
		for (int i = 0; i < MaxResults; i++) begin
			slot[i].last = lst[i];
			slot[i].data = raw[i];
			if (SlotCntW'(i) < n && !lst[i]) begin
				f            = fold_byte(raw[i], c3);
				slot[i].data = f[ByteW-1:0];
				c3           = f[ByteW];
			end
		end

		n_push = n;
		if (!captured && b == ChNul) begin
			// terminator returns everything to the idle state
			held_kind_d   = HELD_NONE;
			held_second_d = 1'b0;
			space_pend_d  = 1'b0;
			emitted_d     = 1'b0;
			prev_c3_d     = 1'b0;
		end else begin
			space_pend_d = sp;
			emitted_d    = em;
			prev_c3_d    = c3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_kind_q   <= HELD_NONE;
			held_second_q <= 1'b0;
			space_pend_q  <= 1'b0;
			emitted_q     <= 1'b0;
			prev_c3_q     <= 1'b0;
		end else if (advance) begin
			held_kind_q   <= held_kind_d;
			held_second_q <= held_second_d;
			space_pend_q  <= space_pend_d;
			emitted_q     <= emitted_d;
			prev_c3_q     <= prev_c3_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MaxResults; i++) begin
			if (SlotCntW'(i) < push_cnt) fifo_mem[wr_ptr_q + FifoPtrW'(i)] <= slot[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			wr_ptr_q   <= wr_ptr_q + FifoPtrW'(push_cnt);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			fifo_cnt_q <= fifo_cnt_q + FifoCntW'(push_cnt) - FifoCntW'(pop);
		end
	end

	assign m_tvalid = (fifo_cnt_q != '0);
	assign m_tdata  = fifo_mem[rd_ptr_q].data;
	assign m_tlast  = fifo_mem[rd_ptr_q].last;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= FifoCntW'(FifoDepth))
		else $error("output queue overflow");

	a_second_needs_lead: assert property (@(posedge clk) disable iff (!arst_n)
		held_second_q |-> (held_kind_q == HELD_E2 || held_kind_q == HELD_E3))
		else $error("continuation held without three-byte lead");

	a_last_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata == ChNul))
		else $error("terminator word carries data");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && byte_s1 == ChNul && held_kind_q == HELD_NONE) |=>
		(!emitted_q && !space_pend_q && !prev_c3_q && held_kind_q == HELD_NONE))
		else $error("state not cleared after terminator");

	a_pend_needs_text: assert property (@(posedge clk) disable iff (!arst_n)
		space_pend_q |-> emitted_q)
		else $error("space pending before any text");

endmodule

// File: sim/utf8_whitespace_collapse_lower_tb.sv
module utf8_whitespace_collapse_lower_tb;
	import uwcl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QuietLimit = 1000;
	localparam int RandomBytes = 215;

	typedef struct {
		logic [ByteW-1:0] value;
		int               gap;
		bit               drain_first;
	} send_item_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [ByteW-1:0] s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [ByteW-1:0] m_tdata;
	logic             m_tlast;

	send_item_t pending[$];
	out_word_t  expected_words[$];
	bit         calm;
	bit         hold_next;
	int         gap_left;
	int         stall_left;
	int         quiet;
	int         depth_was;
	int         stall_draw;
	out_word_t  want;

	int unsigned bytes_sent;
	int unsigned strings_done;
	int unsigned words_checked;
	int unsigned bursts_full;
	int unsigned mismatches;

	// predictor state
	held_kind_t held_kind;
	logic       held_second;
	logic       space_due;
	logic       text_seen;
	logic       last_c3;

	utf8_whitespace_collapse_lower i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic clear_scan();
		held_kind   = HELD_NONE;
		held_second = 1'b0;
		space_due   = 1'b0;
		text_seen   = 1'b0;
		last_c3     = 1'b0;
	endtask

	task automatic push_lower(input logic [ByteW-1:0] b);
		out_word_t w;
		w.last = 1'b0;
		w.data = b;
		// the byte right after an emitted c3 lead folds latin-1 capitals
		if (last_c3 && b >= ChCont && b <= ChFoldHi && b != ChTimes) begin
			w.data  = b + CaseOfs;
			last_c3 = 1'b0;
		end else begin
			if (b >= ChUpA && b <= ChUpZ) w.data = b + CaseOfs;
			last_c3 = (w.data == ChC3);
		end
		expected_words.push_back(w);
	endtask

	task automatic emit_text(input logic [ByteW-1:0] b);
		if (space_due) begin
			push_lower(ChSpace);
			space_due = 1'b0;
		end
		push_lower(b);
		text_seen = 1'b1;
	endtask

	task automatic release_held();
		case (held_kind)
			HELD_C2: emit_text(ChC2);
			HELD_E2: emit_text(ChE2);
			HELD_E3: emit_text(ChE3);
			default: ;
		endcase
		if (held_kind != HELD_NONE && held_second) emit_text(ChCont);
		held_kind   = HELD_NONE;
		held_second = 1'b0;
	endtask

	task automatic enter_space();
		held_kind   = HELD_NONE;
		held_second = 1'b0;
		if (text_seen) space_due = 1'b1;
	endtask

	task automatic collapse_byte(input logic [ByteW-1:0] b);
		out_word_t term;
		if (held_kind == HELD_C2) begin
			if (b == ChNbsp2) begin
				enter_space();
				return;
			end
			release_held();
		end else if (held_kind != HELD_NONE && !held_second) begin
			if (b == ChCont) begin
				held_second = 1'b1;
				return;
			end
			release_held();
		end else if (held_kind == HELD_E2) begin
			if (b == ChLsep3 || b == ChPsep3) begin
				enter_space();
				return;
			end
			release_held();
		end else if (held_kind == HELD_E3) begin
			if (b == ChCont) begin
				enter_space();
				return;
			end
			release_held();
		end

		if (b == ChNul) begin
			term.last = 1'b1;
			term.data = ChNul;
			expected_words.push_back(term);
			clear_scan();
			strings_done++;
		end else if (b == ChSpace || (b >= ChTab && b <= ChCr)) begin
			enter_space();
		end else if (b == ChC2) begin
			held_kind = HELD_C2;
		end else if (b == ChE2) begin
			held_kind = HELD_E2;
		end else if (b == ChE3) begin
			held_kind = HELD_E3;
		end else begin
			emit_text(b);
		end
	endtask

	task automatic queue_byte(input logic [ByteW-1:0] b);
		send_item_t it;
		it.value       = b;
		it.gap         = calm ? 0 : $urandom_range(0, 15);
		it.drain_first = hold_next;
		hold_next      = 1'b0;
		pending.push_back(it);
	endtask

	// sender: gap counts idle cycles after a word is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_left <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending.size() != 0 &&
					!(pending[0].drain_first && (s_tvalid || expected_words.size() != 0))) begin
				s_tdata  <= pending[0].value;
				s_tvalid <= 1'b1;
				gap_left <= pending[0].gap;
				void'(pending.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: predicts on each input word, then checks output words in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				depth_was = expected_words.size();
				collapse_byte(s_tdata);
				if (expected_words.size() - depth_was == MaxResults) bursts_full++;
				bytes_sent++;
			end
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					if (mismatches < 10)
						$display("tb: unexpected word data %02h last %0b", m_tdata, m_tlast);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (m_tdata !== want.data || m_tlast !== want.last) begin
						if (mismatches < 10)
							$display("tb: word %0d expected data %02h last %0b, got data %02h last %0b",
								words_checked, want.data, want.last, m_tdata, m_tlast);
						mismatches++;
					end
				end
				words_checked++;
				stall_draw = (words_checked % 64 < 16) ? 0 : $urandom_range(0, 15);
				if (stall_draw == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready   <= 1'b0;
					stall_left <= stall_draw;
				end
			end else if (!m_tready) begin
				if (stall_left <= 1) m_tready <= 1'b1;
				stall_left <= stall_left - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet >= QuietLimit) begin
			$display("tb: timeout with %0d words still expected", expected_words.size());
			$display("tb: failure");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		logic [ByteW-1:0] directed[$];
		int               sent_random;
		int               pieces;
		int               kind;
		int               n_string;

		directed = '{
			// all whitespace, then leading/inner/trailing runs with folds
			8'h20, 8'hC2, 8'hA0, 8'h00,
			8'h09, 8'h41, 8'hE2, 8'h80, 8'hA8, 8'h0D, 8'h5A, 8'hC3, 8'h80, 8'hC3, 8'h97,
			8'hC3, 8'h9E, 8'hC2, 8'hE3, 8'h80, 8'h80, 8'hFF, 8'h20, 8'h00,
			// broken sequences, widest burst, end with bytes held
			8'h61, 8'h20, 8'hE2, 8'h80, 8'h62, 8'hE3, 8'hC3, 8'hE3, 8'h80, 8'h00
		};
		clear_scan();
		calm = 1'b0;
		hold_next = 1'b0;
		foreach (directed[i]) queue_byte(directed[i]);

		sent_random = 0;
		n_string = 0;
		hold_next = 1'b1;
		while (sent_random < RandomBytes) begin
			calm = ($urandom_range(0, 3) == 0);
			if (n_string == 12) hold_next = 1'b1;
			pieces = $urandom_range(0, 8);
			repeat (pieces) begin
				kind = $urandom_range(0, 99);
				if (kind < 25) begin
					queue_byte($urandom_range(0, 1) ? ChSpace : 8'($urandom_range(9, 13)));
				end else if (kind < 37) begin
					case ($urandom_range(0, 3))
						0: begin queue_byte(ChC2); queue_byte(ChNbsp2); end
						1: begin queue_byte(ChE2); queue_byte(ChCont); queue_byte(ChLsep3); end
						2: begin queue_byte(ChE2); queue_byte(ChCont); queue_byte(ChPsep3); end
						default: begin queue_byte(ChE3); queue_byte(ChCont); queue_byte(ChCont); end
					endcase
				end else if (kind < 52) begin
					// prefix of a multi-byte space, often followed by a breaking byte
					case ($urandom_range(0, 4))
						0: queue_byte(ChC2);
						1: queue_byte(ChE2);
						2: begin queue_byte(ChE2); queue_byte(ChCont); end
						3: queue_byte(ChE3);
						default: begin queue_byte(ChE3); queue_byte(ChCont); end
					endcase
					if (kind < 47) queue_byte(8'($urandom_range(1, 255)));
				end else if (kind < 67) begin
					queue_byte(ChC3);
					queue_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 255))
						: 8'($urandom_range(8'h7E, 8'hA0)));
				end else if (kind < 80) begin
					queue_byte(8'($urandom_range(8'h40, 8'h5B)));
				end else begin
					queue_byte(8'($urandom_range(1, 255)));
				end
			end
			queue_byte(ChNul);
			n_string++;
			sent_random = pending.size() - directed.size();
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending.size() == 0 && !s_tvalid);
		wait (expected_words.size() == 0);
		repeat (20) @(posedge clk);

		$display("tb: %0d bytes over %0d strings, %0d output words checked",
			bytes_sent, strings_done, words_checked);
		$display("tb: %0d bytes gave a four-word burst, %0d mismatches", bursts_full, mismatches);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/uwcl_pkg.sv
hw/rtl/utf8_whitespace_collapse_lower.sv
sim/utf8_whitespace_collapse_lower_tb.sv
